FILE: rtl/core/omni_three_wheel_kinematics_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the omni three-wheel kinematics block
// Concurrent checks clocked on a rising edge and held off while reset is low.
// Synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef OMNI_THREE_WHEEL_KINEMATICS_MACROS_SVH
`define OMNI_THREE_WHEEL_KINEMATICS_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons holds at that edge.
`define OTWK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("otwk: same-cycle check failed");

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define OTWK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("otwk: next-cycle check failed");

`else

`define OTWK_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OTWK_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/otwk_pkg.sv
// ----------------------------------------------------------------------------
// otwk_pkg
// Shared widths, angle constants, queue item type and the cosine table.
// ----------------------------------------------------------------------------
package otwk_pkg;

    localparam int CoefFracBits = 16;
    localparam int DataW        = 16;
    localparam int CoefW        = CoefFracBits + 1;
    localparam int AngleW       = 9;
    localparam int RemW         = AngleW + 1;
    localparam int QuadW        = 7;
    localparam int QuotW        = 8;
    localparam int ProdW        = 2 * DataW;
    localparam int RecipShift   = 24;

    // floor(2^24 / 360); underestimates the quotient by at most one
    localparam logic [DataW-1:0] RecipMul = DataW'((1 << RecipShift) / 360);

    localparam logic [AngleW-1:0] Angle90   = AngleW'(90);
    localparam logic [AngleW-1:0] Angle180  = AngleW'(180);
    localparam logic [AngleW-1:0] Angle270  = AngleW'(270);
    localparam logic [AngleW-1:0] AngleFull = AngleW'(360);

    // wheel mounting offsets: a sees cos(h+180), b cos(h+60), c cos(h+300)
    localparam logic [AngleW-1:0] OffsetA = AngleW'(180);
    localparam logic [AngleW-1:0] OffsetB = AngleW'(60);
    localparam logic [AngleW-1:0] OffsetC = AngleW'(300);

    localparam int NumWheels  = 3;
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    typedef struct packed {
        logic [QuadW-1:0] k;
        logic             neg;
    } t_wheel_cmd;

    typedef struct packed {
        t_wheel_cmd       a;
        t_wheel_cmd       b;
        t_wheel_cmd       c;
        logic [DataW-1:0] speed;
    } t_queue_item;

    // round(65536 * cos(k degrees)), k = 0..90
    function automatic logic [CoefW-1:0] coef_mag(input logic [QuadW-1:0] k);
        logic [CoefW-1:0] v;
        unique case (k)
            7'd0:  v = 17'd65536;
            7'd1:  v = 17'd65526;
            7'd2:  v = 17'd65496;
            7'd3:  v = 17'd65446;
            7'd4:  v = 17'd65376;
            7'd5:  v = 17'd65287;
            7'd6:  v = 17'd65177;
            7'd7:  v = 17'd65048;
            7'd8:  v = 17'd64898;
            7'd9:  v = 17'd64729;
            7'd10: v = 17'd64540;
            7'd11: v = 17'd64332;
            7'd12: v = 17'd64104;
            7'd13: v = 17'd63856;
            7'd14: v = 17'd63589;
            7'd15: v = 17'd63303;
            7'd16: v = 17'd62997;
            7'd17: v = 17'd62672;
            7'd18: v = 17'd62328;
            7'd19: v = 17'd61966;
            7'd20: v = 17'd61584;
            7'd21: v = 17'd61183;
            7'd22: v = 17'd60764;
            7'd23: v = 17'd60326;
            7'd24: v = 17'd59870;
            7'd25: v = 17'd59396;
            7'd26: v = 17'd58903;
            7'd27: v = 17'd58393;
            7'd28: v = 17'd57865;
            7'd29: v = 17'd57319;
            7'd30: v = 17'd56756;
            7'd31: v = 17'd56175;
            7'd32: v = 17'd55578;
            7'd33: v = 17'd54963;
            7'd34: v = 17'd54332;
            7'd35: v = 17'd53684;
            7'd36: v = 17'd53020;
            7'd37: v = 17'd52339;
            7'd38: v = 17'd51643;
            7'd39: v = 17'd50931;
            7'd40: v = 17'd50203;
            7'd41: v = 17'd49461;
            7'd42: v = 17'd48703;
            7'd43: v = 17'd47930;
            7'd44: v = 17'd47143;
            7'd45: v = 17'd46341;
            7'd46: v = 17'd45525;
            7'd47: v = 17'd44695;
            7'd48: v = 17'd43852;
            7'd49: v = 17'd42995;
            7'd50: v = 17'd42126;
            7'd51: v = 17'd41243;
            7'd52: v = 17'd40348;
            7'd53: v = 17'd39441;
            7'd54: v = 17'd38521;
            7'd55: v = 17'd37590;
            7'd56: v = 17'd36647;
            7'd57: v = 17'd35693;
            7'd58: v = 17'd34729;
            7'd59: v = 17'd33754;
            7'd60: v = 17'd32768;
            7'd61: v = 17'd31772;
            7'd62: v = 17'd30767;
            7'd63: v = 17'd29753;
            7'd64: v = 17'd28729;
            7'd65: v = 17'd27697;
            7'd66: v = 17'd26656;
            7'd67: v = 17'd25607;
            7'd68: v = 17'd24550;
            7'd69: v = 17'd23486;
            7'd70: v = 17'd22415;
            7'd71: v = 17'd21336;
            7'd72: v = 17'd20252;
            7'd73: v = 17'd19161;
            7'd74: v = 17'd18064;
            7'd75: v = 17'd16962;
            7'd76: v = 17'd15855;
            7'd77: v = 17'd14742;
            7'd78: v = 17'd13626;
            7'd79: v = 17'd12505;
            7'd80: v = 17'd11380;
            7'd81: v = 17'd10252;
            7'd82: v = 17'd9121;
            7'd83: v = 17'd7987;
            7'd84: v = 17'd6850;
            7'd85: v = 17'd5712;
            7'd86: v = 17'd4572;
            7'd87: v = 17'd3430;
            7'd88: v = 17'd2287;
            7'd89: v = 17'd1144;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/otwk_front.sv
`include "omni_three_wheel_kinematics_macros.svh"
// ----------------------------------------------------------------------------
// otwk_front
// Reduce the heading modulo 360 and fold each wheel angle into a quadrant.
// ----------------------------------------------------------------------------
module otwk_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [15:0]            i_heading_deg,
    input  logic [15:0]            i_drive_speed,
    output logic                   o_push_valid,
    input  logic                   i_push_ready,
    output otwk_pkg::t_queue_item  o_push_item
);

    function automatic otwk_pkg::t_wheel_cmd classify(
        input logic [otwk_pkg::AngleW-1:0] rem,
        input logic [otwk_pkg::AngleW-1:0] ofs
    );
        logic [otwk_pkg::AngleW:0]   sum;
        logic [otwk_pkg::AngleW-1:0] d;
        otwk_pkg::t_wheel_cmd        cmd;
        sum = {1'b0, rem} + {1'b0, ofs};
        if (sum >= {1'b0, otwk_pkg::AngleFull}) begin
            d = otwk_pkg::AngleW'(sum - {1'b0, otwk_pkg::AngleFull});
        end else begin
            d = sum[otwk_pkg::AngleW-1:0];
        end
        priority if (d <= otwk_pkg::Angle90) begin
            cmd.k   = otwk_pkg::QuadW'(d);
            cmd.neg = 1'b0;
        end else if (d <= otwk_pkg::Angle180) begin
            cmd.k   = otwk_pkg::QuadW'(otwk_pkg::Angle180 - d);
            cmd.neg = 1'b1;
        end else if (d <= otwk_pkg::Angle270) begin
            cmd.k   = otwk_pkg::QuadW'(d - otwk_pkg::Angle180);
            cmd.neg = 1'b1;
        end else begin
            cmd.k   = otwk_pkg::QuadW'(otwk_pkg::AngleFull - d);
            cmd.neg = 1'b0;
        end
        return cmd;
    endfunction

    logic                            r_f1_valid;
    logic [otwk_pkg::DataW-1:0]      r_f1_head;
    logic [otwk_pkg::DataW-1:0]      r_f1_speed;
    logic [otwk_pkg::QuotW-1:0]      r_f1_quot;
    logic                            r_f2_valid;
    logic [otwk_pkg::AngleW-1:0]     r_f2_rem;
    logic [otwk_pkg::DataW-1:0]      r_f2_speed;

    logic [otwk_pkg::ProdW-1:0]      n_f1_prod;
    logic [otwk_pkg::QuotW-1:0]      n_f1_quot;
    logic [otwk_pkg::DataW-1:0]      n_quot_scaled;
    logic [otwk_pkg::DataW-1:0]      n_diff;
    logic [otwk_pkg::RemW-1:0]       n_diff_lo;
    logic [otwk_pkg::AngleW-1:0]     n_f2_rem;
    logic                            w_f1_adv;
    logic                            w_f2_adv;

    assign w_f2_adv   = !r_f2_valid || i_push_ready;
    assign w_f1_adv   = !r_f1_valid || w_f2_adv;
    assign o_in_ready = w_f1_adv;

    // Quotient estimate by reciprocal; may be one short.
    assign n_f1_prod = {{(otwk_pkg::ProdW - otwk_pkg::DataW){1'b0}}, i_heading_deg}
                     * {{(otwk_pkg::ProdW - otwk_pkg::DataW){1'b0}}, otwk_pkg::RecipMul};
    assign n_f1_quot = n_f1_prod[otwk_pkg::RecipShift +: otwk_pkg::QuotW];

    // Remainder lands below 720; one subtract finishes it.
    assign n_quot_scaled = {{(otwk_pkg::DataW - otwk_pkg::QuotW){1'b0}}, r_f1_quot}
                         * {{(otwk_pkg::DataW - otwk_pkg::AngleW){1'b0}}, otwk_pkg::AngleFull};
    assign n_diff    = r_f1_head - n_quot_scaled;
    assign n_diff_lo = n_diff[otwk_pkg::RemW-1:0];

    always_comb begin
        if (n_diff_lo >= {1'b0, otwk_pkg::AngleFull}) begin
            n_f2_rem = otwk_pkg::AngleW'(n_diff_lo - {1'b0, otwk_pkg::AngleFull});
        end else begin
            n_f2_rem = n_diff_lo[otwk_pkg::AngleW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            if (w_f1_adv) begin
                r_f1_valid <= i_in_valid;
            end
            if (w_f2_adv) begin
                r_f2_valid <= r_f1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_f1_adv && i_in_valid) begin
            r_f1_head  <= i_heading_deg;
            r_f1_speed <= i_drive_speed;
            r_f1_quot  <= n_f1_quot;
        end
        if (w_f2_adv && r_f1_valid) begin
            r_f2_rem   <= n_f2_rem;
            r_f2_speed <= r_f1_speed;
        end
    end

    assign o_push_valid      = r_f2_valid;
    assign o_push_item.a     = classify(r_f2_rem, otwk_pkg::OffsetA);
    assign o_push_item.b     = classify(r_f2_rem, otwk_pkg::OffsetB);
    assign o_push_item.c     = classify(r_f2_rem, otwk_pkg::OffsetC);
    assign o_push_item.speed = r_f2_speed;

    `OTWK_ASSERT_IMPL(a_rem_range, i_clk, i_rst_n, r_f2_valid, r_f2_rem < otwk_pkg::AngleFull)

endmodule

FILE: rtl/core/otwk_queue.sv
`include "omni_three_wheel_kinematics_macros.svh"
// ----------------------------------------------------------------------------
// otwk_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module otwk_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_valid,
    output logic                   o_wr_ready,
    input  otwk_pkg::t_queue_item  i_wr_item,
    output logic                   o_rd_valid,
    input  logic                   i_rd_ready,
    output otwk_pkg::t_queue_item  o_rd_item
);

    localparam logic [otwk_pkg::QueueCntW-1:0] Full =
        otwk_pkg::QueueCntW'(otwk_pkg::QueueDepth);
    localparam logic [otwk_pkg::QueuePtrW-1:0] LastPtr =
        otwk_pkg::QueuePtrW'(otwk_pkg::QueueDepth - 1);

    otwk_pkg::t_queue_item              r_mem [otwk_pkg::QueueDepth];
    logic [otwk_pkg::QueuePtrW-1:0]     r_wr_ptr;
    logic [otwk_pkg::QueuePtrW-1:0]     r_rd_ptr;
    logic [otwk_pkg::QueueCntW-1:0]     r_count;
    logic [otwk_pkg::QueuePtrW-1:0]     n_wr_ptr;
    logic [otwk_pkg::QueuePtrW-1:0]     n_rd_ptr;
    logic [otwk_pkg::QueueCntW-1:0]     n_count;
    logic                               w_push;
    logic                               w_pop;

    assign o_wr_ready = (r_count != Full);
    assign o_rd_valid = (r_count != '0);
    assign o_rd_item  = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    `OTWK_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= Full)
    `OTWK_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, w_pop && !w_push, r_count == $past(r_count) - 1'b1)

endmodule

FILE: rtl/core/otwk_back.sv
`include "omni_three_wheel_kinematics_macros.svh"
// ----------------------------------------------------------------------------
// otwk_back
// Look up wheel coefficients, scale by speed and hold the result for output.
// ----------------------------------------------------------------------------
module otwk_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    output logic                   o_cmd_ready,
    input  otwk_pkg::t_queue_item  i_cmd_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [15:0]            o_wheel_a_mag,
    output logic                   o_wheel_a_ccw,
    output logic                   o_wheel_a_on,
    output logic [15:0]            o_wheel_b_mag,
    output logic                   o_wheel_b_ccw,
    output logic                   o_wheel_b_on,
    output logic [15:0]            o_wheel_c_mag,
    output logic                   o_wheel_c_ccw,
    output logic                   o_wheel_c_on
);

    localparam int MulW = otwk_pkg::DataW + otwk_pkg::CoefW;

    typedef struct packed {
        logic [otwk_pkg::CoefW-1:0] mag;
        logic                       neg;
    } t_wheel_coef;

    logic                              r_b1_valid;
    t_wheel_coef                       r_b1_coef [otwk_pkg::NumWheels];
    logic [otwk_pkg::DataW-1:0]        r_b1_speed;
    logic                              r_b2_valid;
    logic [otwk_pkg::DataW-1:0]        r_mag [otwk_pkg::NumWheels];
    logic [otwk_pkg::NumWheels-1:0]    r_ccw;
    logic [otwk_pkg::NumWheels-1:0]    r_on;

    otwk_pkg::t_wheel_cmd              w_cmd [otwk_pkg::NumWheels];
    logic [MulW-1:0]                   n_prod [otwk_pkg::NumWheels];
    logic [otwk_pkg::DataW-1:0]        n_mag [otwk_pkg::NumWheels];
    logic [otwk_pkg::NumWheels-1:0]    n_ccw;
    logic [otwk_pkg::NumWheels-1:0]    n_on;
    logic                              w_b1_adv;
    logic                              w_b2_adv;

    assign w_b2_adv    = !r_b2_valid || i_out_ready;
    assign w_b1_adv    = !r_b1_valid || w_b2_adv;
    assign o_cmd_ready = w_b1_adv;

    assign w_cmd[0] = i_cmd_item.a;
    assign w_cmd[1] = i_cmd_item.b;
    assign w_cmd[2] = i_cmd_item.c;

    // Truncate toward zero on the magnitude; sign only steers direction.
    always_comb begin
        for (int i = 0; i < otwk_pkg::NumWheels; i++) begin
            n_prod[i] = {{(MulW - otwk_pkg::DataW){1'b0}}, r_b1_speed}
                      * {{(MulW - otwk_pkg::CoefW){1'b0}}, r_b1_coef[i].mag};
            n_mag[i]  = n_prod[i][otwk_pkg::CoefFracBits +: otwk_pkg::DataW];
            n_on[i]   = (n_mag[i] != '0);
            n_ccw[i]  = n_on[i] && !r_b1_coef[i].neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
        end else begin
            if (w_b1_adv) begin
                r_b1_valid <= i_cmd_valid;
            end
            if (w_b2_adv) begin
                r_b2_valid <= r_b1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b1_adv && i_cmd_valid) begin
            for (int i = 0; i < otwk_pkg::NumWheels; i++) begin
                r_b1_coef[i].mag <= otwk_pkg::coef_mag(w_cmd[i].k);
                r_b1_coef[i].neg <= w_cmd[i].neg;
            end
            r_b1_speed <= i_cmd_item.speed;
        end
        if (w_b2_adv && r_b1_valid) begin
            for (int i = 0; i < otwk_pkg::NumWheels; i++) begin
                r_mag[i] <= n_mag[i];
            end
            r_ccw <= n_ccw;
            r_on  <= n_on;
        end
    end

    assign o_out_valid   = r_b2_valid;
    assign o_wheel_a_mag = r_mag[0];
    assign o_wheel_a_ccw = r_ccw[0];
    assign o_wheel_a_on  = r_on[0];
    assign o_wheel_b_mag = r_mag[1];
    assign o_wheel_b_ccw = r_ccw[1];
    assign o_wheel_b_on  = r_on[1];
    assign o_wheel_c_mag = r_mag[2];
    assign o_wheel_c_ccw = r_ccw[2];
    assign o_wheel_c_on  = r_on[2];

    `OTWK_ASSERT_IMPL(a_on_matches_mag, i_clk, i_rst_n, r_b2_valid, (r_on[0] == (r_mag[0] != '0)) && (r_on[1] == (r_mag[1] != '0)) && (r_on[2] == (r_mag[2] != '0)))
    `OTWK_ASSERT_IMPL(a_ccw_needs_on, i_clk, i_rst_n, r_b2_valid, (r_ccw & ~r_on) == '0)

endmodule

FILE: rtl/core/omni_three_wheel_kinematics.sv
// ----------------------------------------------------------------------------
// omni_three_wheel_kinematics
// Inverse kinematics for a three-wheel omni base: heading and speed in,
// magnitude, direction and enable for each of three wheels out.
// ----------------------------------------------------------------------------
// Each input item (heading in whole degrees, any 16-bit value, plus a speed)
// gives exactly one result item. Wheel a drives -speed*cos(h), wheel b
// speed*cos(h+60) and wheel c speed*cos(h+300), with the heading taken modulo
// 360. Coefficients are cosines rounded to Q1.16 and each product is
// truncated toward zero, so a wheel magnitude never exceeds the speed. The
// ccw bit is set when the wheel value is positive, the on bit when it is
// nonzero; a zero product clears all three fields. Throughput is one item
// per clock while the output is not stalled. A taken item passes through
// two front stages (reciprocal multiply for the quotient by 360, then
// remainder and quadrant fold), the four-entry queue, one table lookup
// stage and one multiply stage that is also the output register. The
// queue lets the front keep taking items while the output is stalled,
// until the queue and the pipeline registers fill.
// ----------------------------------------------------------------------------
module omni_three_wheel_kinematics (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_heading_deg,
    input  logic [15:0] i_drive_speed,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_wheel_a_mag,
    output logic        o_wheel_a_ccw,
    output logic        o_wheel_a_on,
    output logic [15:0] o_wheel_b_mag,
    output logic        o_wheel_b_ccw,
    output logic        o_wheel_b_on,
    output logic [15:0] o_wheel_c_mag,
    output logic        o_wheel_c_ccw,
    output logic        o_wheel_c_on
);

    // front -> queue
    logic                  w_push_valid;
    logic                  w_push_ready;
    otwk_pkg::t_queue_item w_push_item;

    // queue -> back
    logic                  w_cmd_valid;
    logic                  w_cmd_ready;
    otwk_pkg::t_queue_item w_cmd_item;

    // Reduce the heading and fold each wheel angle into the first quadrant.
    otwk_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_heading_deg (i_heading_deg),
        .i_drive_speed (i_drive_speed),
        .o_push_valid  (w_push_valid),
        .i_push_ready  (w_push_ready),
        .o_push_item   (w_push_item)
    );

    // Hold folded commands so each side can stall on its own.
    otwk_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_push_valid),
        .o_wr_ready (w_push_ready),
        .i_wr_item  (w_push_item),
        .o_rd_valid (w_cmd_valid),
        .i_rd_ready (w_cmd_ready),
        .o_rd_item  (w_cmd_item)
    );

    // Look up coefficients, scale by speed and present the result item.
    otwk_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .o_cmd_ready   (w_cmd_ready),
        .i_cmd_item    (w_cmd_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_wheel_a_mag (o_wheel_a_mag),
        .o_wheel_a_ccw (o_wheel_a_ccw),
        .o_wheel_a_on  (o_wheel_a_on),
        .o_wheel_b_mag (o_wheel_b_mag),
        .o_wheel_b_ccw (o_wheel_b_ccw),
        .o_wheel_b_on  (o_wheel_b_on),
        .o_wheel_c_mag (o_wheel_c_mag),
        .o_wheel_c_ccw (o_wheel_c_ccw),
        .o_wheel_c_on  (o_wheel_c_on)
    );

endmodule
